// ===== rtl/lod_pkg.sv =====
package lod_pkg;

    // request opcodes (input tuser)
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ORBIT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BAND_TOP    = 2'd0;
    localparam logic [1:0] CFG_PLOT_BOTTOM = 2'd1;
    localparam logic [1:0] CFG_WARMUP      = 2'd2;
    localparam logic [1:0] CFG_PLOT_STEPS  = 2'd3;

    // fixed point: x is Q1.30, r is Q3.28
    localparam logic [30:0] X_ONE  = 31'h4000_0000;
    localparam logic [30:0] X_HALF = 31'h2000_0000;
    localparam logic [30:0] R_FOUR = 31'h4000_0000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_ORBIT,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        rejected;
        logic [30:0] r_value;
        logic [8:0]  column;
        logic [6:0]  cell_row;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  band_top;
        logic [7:0]  plot_bottom;
        logic [11:0] warmup_steps;
        logic [11:0] plot_steps;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_ORBIT_P,
        ST_ORBIT_Y,
        ST_DRAIN,
        ST_REPLY
    } t_state;

endpackage

// ===== rtl/lod_front.sv =====
module lod_front #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 320
) (
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [47:0]   i_tdata,   // r_value[30:0], column[39:31], cell_row[46:40]
    input  logic [1:0]    i_tuser,   // opcode[1:0]
    input  lod_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    input  logic          i_init_busy,
    output logic          o_push,
    output lod_pkg::t_cmd o_cmd
);

    logic [1:0]  opcode;
    logic [30:0] r_in;
    logic [8:0]  col_in;
    logic [6:0]  row_in;
    logic        col_ok;
    logic        row_ok;
    logic        band_ok;
    logic        r_bad;

    assign opcode = i_tuser;
    assign r_in   = i_tdata[30:0];
    assign col_in = i_tdata[39:31];
    assign row_in = i_tdata[46:40];

    assign col_ok  = int'(col_in) < GRID_COLS;
    assign row_ok  = int'(row_in) < GRID_ROWS;
    // band needs at least two rows
    assign band_ok = {1'b0, i_cfg.plot_bottom} >= (9'(i_cfg.band_top) + 9'd2);
    assign r_bad   = (r_in == '0) || (r_in > lod_pkg::R_FOUR);

    assign o_tready = !i_q_full && !i_init_busy;
    assign o_push   = i_tvalid && o_tready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.r_value  = r_in;
        o_cmd.column   = col_in;
        o_cmd.cell_row = row_in;
        o_cmd.kind     = lod_pkg::CMD_NOP;
        o_cmd.rejected = 1'b0;
        unique case (opcode)
            lod_pkg::OP_CLEAR: begin
                o_cmd.kind = lod_pkg::CMD_CLEAR;
            end
            lod_pkg::OP_ORBIT: begin
                if (r_bad) begin
                    o_cmd.rejected = 1'b1;
                end else if (col_ok && band_ok) begin
                    o_cmd.kind = lod_pkg::CMD_ORBIT;
                end
            end
            lod_pkg::OP_READ: begin
                if (col_ok && row_ok) begin
                    o_cmd.kind = lod_pkg::CMD_READ;
                end
            end
            default: begin
                o_cmd.kind = lod_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/lod_queue.sv =====
module lod_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lod_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output lod_pkg::t_cmd o_cmd
);

    lod_pkg::t_cmd                 r_slot [lod_pkg::QUEUE_DEPTH];
    logic [lod_pkg::QPTR_W-1:0]    r_wptr;
    logic [lod_pkg::QPTR_W-1:0]    r_rptr;
    logic [lod_pkg::QPTR_W:0]      r_count;

    assign o_full  = r_count == (lod_pkg::QPTR_W + 1)'(lod_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/lod_back.sv =====
module lod_back #(
    parameter int GRID_ROWS  = 128,
    parameter int GRID_COLS  = 320,
    parameter int COUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lod_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  lod_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_init_busy,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output logic [15:0]   o_cell,
    output logic [15:0]   o_peak,
    output logic          o_rej
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [ADDR_W-1:0] f_addr(input logic [8:0] row,
                                                 input logic [8:0] col);
        f_addr = ADDR_W'(32'(row) * 32'(GRID_COLS) + 32'(col));
    endfunction

    lod_pkg::t_state         r_state, n_state;
    lod_pkg::t_cmd           r_cmd, n_cmd;
    logic [30:0]             r_x, n_x;
    logic [28:0]             r_p, n_p;
    logic [12:0]             r_step, n_step;
    logic [7:0]              r_h1, n_h1;
    logic [ADDR_W-1:0]       r_sweep, n_sweep;
    logic                    r_xplot, n_xplot;
    logic [7:0]              r_t;
    logic                    r_vt;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_va;
    logic [COUNT_BITS-1:0]   r_rd;
    logic [ADDR_W-1:0]       r_waddr;
    logic                    r_vr;
    logic [COUNT_BITS-1:0]   r_peak;
    logic                    r_out_valid;
    logic [COUNT_BITS-1:0]   r_out_cell;
    logic [COUNT_BITS-1:0]   r_out_peak;
    logic                    r_out_rej;
    logic [COUNT_BITS-1:0]   r_grid [DEPTH];

    logic [7:0]              cfg_h1;
    logic [12:0]             cfg_total;
    logic [61:0]             prod_p;
    logic [59:0]             prod_y;
    logic [31:0]             y_full;
    logic [30:0]             x_next;
    logic [38:0]             prod_t;
    logic [8:0]              stamp_row;
    logic                    stamp_ok;
    logic [COUNT_BITS-1:0]   inc;
    logic                    sweeping;
    logic                    peak_clr;
    logic                    load_out;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [COUNT_BITS-1:0]   mem_wd;
    logic [31:0]             cell_wide;
    logic [31:0]             peak_wide;

    assign cfg_h1    = 8'(i_cfg.plot_bottom - 8'(i_cfg.band_top) - 8'd1);
    assign cfg_total = 13'(i_cfg.warmup_steps) + 13'(i_cfg.plot_steps);

    // x*(1-x) and r*p, each in its own state (ST_ORBIT_P, ST_ORBIT_Y)
    assign prod_p = 62'(r_x) * 62'(lod_pkg::X_ONE - r_x);
    assign prod_y = 60'(r_cmd.r_value) * 60'(r_p);
    assign y_full = prod_y[59:28];
    assign x_next = (y_full > 32'(lod_pkg::X_ONE)) ? lod_pkg::X_ONE : y_full[30:0];

    // rounded row offset, at most h-1
    assign prod_t    = 39'(r_x) * 39'(r_h1) + 39'(lod_pkg::X_HALF);
    assign stamp_row = 9'(i_cfg.band_top) + 9'(r_h1) - 9'(r_t);
    assign stamp_ok  = int'(stamp_row) < GRID_ROWS;

    assign inc = (r_rd == COUNT_MAX) ? r_rd : r_rd + COUNT_BITS'(1);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_x      = r_x;
        n_p      = r_p;
        n_step   = r_step;
        n_h1     = r_h1;
        n_sweep  = r_sweep;
        n_xplot  = 1'b0;
        o_q_pop  = 1'b0;
        sweeping = 1'b0;
        peak_clr = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            lod_pkg::ST_INIT, lod_pkg::ST_CLEAR: begin
                sweeping = 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_sweep = '0;
                    n_state = (r_state == lod_pkg::ST_INIT) ? lod_pkg::ST_IDLE
                                                             : lod_pkg::ST_REPLY;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            lod_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_x     = lod_pkg::X_HALF;
                    n_step  = '0;
                    n_h1    = cfg_h1;
                    unique case (i_q_cmd.kind)
                        lod_pkg::CMD_CLEAR: begin
                            peak_clr = 1'b1;
                            n_state  = lod_pkg::ST_CLEAR;
                        end
                        lod_pkg::CMD_READ: n_state = lod_pkg::ST_RD_ADDR;
                        lod_pkg::CMD_ORBIT: begin
                            n_state = (cfg_total == '0) ? lod_pkg::ST_DRAIN
                                                        : lod_pkg::ST_ORBIT_P;
                        end
                        default: n_state = lod_pkg::ST_REPLY;
                    endcase
                end
            end
            lod_pkg::ST_RD_ADDR: n_state = lod_pkg::ST_RD_MEM;
            lod_pkg::ST_RD_MEM:  n_state = lod_pkg::ST_REPLY;
            lod_pkg::ST_ORBIT_P: begin
                n_p     = prod_p[58:30];
                n_state = lod_pkg::ST_ORBIT_Y;
            end
            lod_pkg::ST_ORBIT_Y: begin
                n_x     = x_next;
                n_xplot = r_step >= 13'(i_cfg.warmup_steps);
                n_step  = r_step + 13'd1;
                n_state = ((r_step + 13'd1) == cfg_total) ? lod_pkg::ST_DRAIN
                                                          : lod_pkg::ST_ORBIT_P;
            end
            lod_pkg::ST_DRAIN: begin
                if (!r_xplot && !r_vt && !r_va && !r_vr) begin
                    n_state = lod_pkg::ST_REPLY;
                end
            end
            lod_pkg::ST_REPLY: begin
                if (!r_out_valid || i_m_ready) begin
                    load_out = 1'b1;
                    n_state  = lod_pkg::ST_IDLE;
                end
            end
            default: n_state = lod_pkg::ST_IDLE;
        endcase
    end

    assign mem_we = sweeping || r_vr;
    assign mem_wa = sweeping ? r_sweep : r_waddr;
    assign mem_wd = sweeping ? '0 : inc;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_wa] <= mem_wd;
        end
        r_rd <= r_grid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lod_pkg::ST_INIT;
            r_sweep     <= '0;
            r_xplot     <= 1'b0;
            r_vt        <= 1'b0;
            r_va        <= 1'b0;
            r_vr        <= 1'b0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_xplot <= n_xplot;
            r_vt    <= r_xplot;
            r_va    <= r_vt && stamp_ok;
            r_vr    <= r_va;
            if (peak_clr) begin
                r_peak <= '0;
            end else if (r_vr && (inc > r_peak)) begin
                r_peak <= inc;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_x     <= n_x;
        r_p     <= n_p;
        r_step  <= n_step;
        r_h1    <= n_h1;
        r_t     <= prod_t[37:30];
        r_waddr <= r_addr;
        if (r_state == lod_pkg::ST_RD_ADDR) begin
            r_addr <= f_addr({2'b00, r_cmd.cell_row}, r_cmd.column);
        end else if (r_vt) begin
            r_addr <= f_addr(stamp_row, r_cmd.column);
        end
        if (load_out) begin
            r_out_cell <= (r_cmd.kind == lod_pkg::CMD_READ) ? r_rd : '0;
            r_out_peak <= r_peak;
            r_out_rej  <= r_cmd.rejected;
        end
    end

    assign cell_wide   = 32'(r_out_cell);
    assign peak_wide   = 32'(r_out_peak);
    assign o_cell      = cell_wide[15:0];
    assign o_peak      = peak_wide[15:0];
    assign o_rej       = r_out_rej;
    assign o_m_valid   = r_out_valid;
    assign o_init_busy = r_state == lod_pkg::ST_INIT;

endmodule

// ===== rtl/logistic_orbit_density_accumulator.sv =====
// The back end handles one request at a time; each map step of an accumulate runs
// through ST_ORBIT_P and then ST_ORBIT_Y.
// Reset: synchronous, active low; then a clearing pass zeroes the grid with
// s_axis_tready low.
module logistic_orbit_density_accumulator #(
    parameter int GRID_ROWS  = 128,
    parameter int GRID_COLS  = 320,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // r_value[30:0], column[39:31], cell_row[46:40]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // cell_count[15:0], peak_count[31:16]
    output logic [0:0]  m_axis_tuser   // r_rejected[0]
);

    lod_pkg::t_cfg r_cfg;
    lod_pkg::t_cmd push_cmd;
    lod_pkg::t_cmd q_cmd;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          init_busy;
    logic [15:0]   cell_cnt;
    logic [15:0]   peak;
    logic          rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_top     <= 7'd2;
            r_cfg.plot_bottom  <= 8'd127;
            r_cfg.warmup_steps <= 12'd500;
            r_cfg.plot_steps   <= 12'd1500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lod_pkg::CFG_BAND_TOP:    r_cfg.band_top     <= i_cfg_data[6:0];
                lod_pkg::CFG_PLOT_BOTTOM: r_cfg.plot_bottom  <= i_cfg_data[7:0];
                lod_pkg::CFG_WARMUP:      r_cfg.warmup_steps <= i_cfg_data;
                lod_pkg::CFG_PLOT_STEPS:  r_cfg.plot_steps   <= i_cfg_data;
                default:                  r_cfg              <= r_cfg;
            endcase
        end
    end

    lod_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    lod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    lod_back #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_cell      (cell_cnt),
        .o_peak      (peak),
        .o_rej       (rej)
    );

    assign m_axis_tdata = {peak, cell_cnt};
    assign m_axis_tuser = rej;

endmodule

// ===== rtl/lod_checker.sv =====
module lod_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                             && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a rejected r never carries a cell count
    a_rej_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("rejected request with nonzero cell count");

    // grid clearing pass runs after reset, no requests taken
    a_init_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request path open right after reset");

endmodule

bind logistic_orbit_density_accumulator lod_checker u_lod_checker (.*);
